FILE: sv/u8cpd_pkg.sv
// Shared types and constants for the UTF-8 code point decoder.
// Used by the decode core, the result buffer, the register block and the top level.
// No dependencies.
package u8cpd_pkg;

   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned CP_W         = 21;
   localparam int unsigned PARTIAL_W    = 15;
   localparam int unsigned REMAIN_W     = 2;
   localparam int unsigned REQ_DATA_W   = 8;
   localparam int unsigned RSP_DATA_W   = 24;
   localparam int unsigned CSR_ADDR_W   = 2;
   localparam int unsigned CSR_DATA_W   = 32;

   // Register byte addresses.
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_MODE = 2'd0;

   // Encoding modes.
   localparam logic MODE_UTF8 = 1'b0;
   localparam logic MODE_RAW  = 1'b1;

   // Lead byte class limits and payload masks.
   localparam logic [BYTE_W-1:0] LEAD_ASCII_MAX = 8'h7F;
   localparam logic [BYTE_W-1:0] LEAD_TWO_MAX   = 8'hDF;
   localparam logic [BYTE_W-1:0] LEAD_THREE_MAX = 8'hEF;
   localparam logic [BYTE_W-1:0] LEAD_FOUR_MAX  = 8'hF4;
   localparam logic [BYTE_W-1:0] MASK_TWO       = 8'h1F;
   localparam logic [BYTE_W-1:0] MASK_THREE     = 8'h0F;
   localparam logic [BYTE_W-1:0] MASK_FOUR      = 8'h07;
   localparam logic [BYTE_W-1:0] MASK_CONT      = 8'h3F;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            end_of_text;
   } result_type;

   // One decoded result handed from the decode core to the result buffer.
   typedef struct packed {
      logic       valid;
      result_type data;
   } result_beat_type;

endpackage

FILE: sv/u8cpd_csr.sv
// Configuration register block: holds the encoding mode behind an APB-style port.
// Depends on u8cpd_pkg.
module u8cpd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [u8cpd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [u8cpd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [u8cpd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready,
   output logic                             mode
);
   import u8cpd_pkg::*;

   logic mode_ff;
   logic mode_in;
   logic wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      mode_in = mode_ff;
      if (wr_en && (csr_paddr == CSR_ADDR_MODE)) begin
         mode_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_UTF8;
      end else begin
         mode_ff <= mode_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == CSR_ADDR_MODE) begin
         csr_prdata = {{(CSR_DATA_W-1){1'b0}}, mode_ff};
      end
   end

   assign mode = mode_ff;

endmodule

FILE: sv/u8cpd_decode.sv
// Decode core: sequence state registers and the per-byte decode logic.
// Depends on u8cpd_pkg.
module u8cpd_decode (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         beat_en,
   input  logic [u8cpd_pkg::BYTE_W-1:0] in_byte,
   input  logic                         mode,
   output u8cpd_pkg::result_beat_type   result
);
   import u8cpd_pkg::*;

   logic [PARTIAL_W-1:0] partial_ff;
   logic [PARTIAL_W-1:0] partial_in;
   logic [REMAIN_W-1:0]  remain_ff;
   logic [REMAIN_W-1:0]  remain_in;
   logic [CP_W-1:0]      merged;
   logic [BYTE_W-1:0]    lead_bits;

   assign merged = {partial_ff, in_byte[5:0] & MASK_CONT[5:0]};

   always_comb begin
      partial_in         = partial_ff;
      remain_in          = remain_ff;
      result.valid       = 1'b0;
      result.data        = '0;
      lead_bits          = '0;

      if (remain_ff != '0) begin
         // Continuation bytes are merged without any checking.
         if (remain_ff == REMAIN_W'(1)) begin
            result.valid           = 1'b1;
            result.data.code_point = merged;
            partial_in             = '0;
            remain_in              = '0;
         end else begin
            partial_in = merged[PARTIAL_W-1:0];
            remain_in  = remain_ff - REMAIN_W'(1);
         end
      end else if (in_byte == '0) begin
         // A zero lead byte ends the text and leaves the state alone.
         result.valid            = 1'b1;
         result.data.end_of_text = 1'b1;
      end else if ((mode == MODE_RAW) || (in_byte <= LEAD_ASCII_MAX) ||
                   (in_byte > LEAD_FOUR_MAX)) begin
         result.valid           = 1'b1;
         result.data.code_point = {{(CP_W-BYTE_W){1'b0}}, in_byte};
      end else if (in_byte <= LEAD_TWO_MAX) begin
         lead_bits  = in_byte & MASK_TWO;
         partial_in = {{(PARTIAL_W-BYTE_W){1'b0}}, lead_bits};
         remain_in  = REMAIN_W'(1);
      end else if (in_byte <= LEAD_THREE_MAX) begin
         lead_bits  = in_byte & MASK_THREE;
         partial_in = {{(PARTIAL_W-BYTE_W){1'b0}}, lead_bits};
         remain_in  = REMAIN_W'(2);
      end else begin
         lead_bits  = in_byte & MASK_FOUR;
         partial_in = {{(PARTIAL_W-BYTE_W){1'b0}}, lead_bits};
         remain_in  = REMAIN_W'(3);
      end

      if (!beat_en) begin
         result.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         remain_ff  <= '0;
      end else if (beat_en) begin
         partial_ff <= partial_in;
         remain_ff  <= remain_in;
      end
   end

endmodule

FILE: sv/u8cpd_out_buf.sv
// Result buffer: an output register with a skid entry behind it.
// Depends on u8cpd_pkg.
module u8cpd_out_buf (
   input  logic                       clock,
   input  logic                       reset,
   input  u8cpd_pkg::result_beat_type push,
   output logic                       push_ready,
   output logic                       out_valid,
   output u8cpd_pkg::result_type      out_data,
   input  logic                       out_ready
);
   import u8cpd_pkg::*;

   logic       main_valid_ff;
   logic       main_valid_in;
   result_type main_data_ff;
   result_type main_data_in;
   logic       skid_valid_ff;
   logic       skid_valid_in;
   result_type skid_data_ff;
   result_type skid_data_in;
   logic       pop;

   assign pop        = main_valid_ff && out_ready;
   assign push_ready = !skid_valid_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // The input side is stalled; drain the skid entry first.
         if (pop) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push.valid) begin
         if (!main_valid_ff || pop) begin
            main_valid_in = 1'b1;
            main_data_in  = push.data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = push.data;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

endmodule

FILE: sv/utf8_codepoint_decoder.sv
// Top level of the UTF-8 code point decoder: register block, decode core, result buffer.
// Depends on u8cpd_pkg, u8cpd_csr, u8cpd_decode and u8cpd_out_buf.
//
//   Channel   Direction  Handshake               Payload
//   req_*     in         req_tvalid/req_tready   tdata[7:0] in_byte
//   rsp_*     out        rsp_tvalid/rsp_tready   tdata[20:0] code_point, tlast end_of_text
//   csr_*     in/out     psel/penable/pready     register 0 at byte 0: encoding_mode
//
// One byte beat is taken per cycle while req_tready is high; a completed code point goes
// to rsp through the output register. Lead and middle bytes of a sequence give no result.
// A two-entry result buffer (output register plus skid entry) keeps req_tready from
// depending on rsp_tready; req_tready drops only while the skid entry is full.
// Reset is synchronous and clears the sequence state, the mode and the buffer.
module utf8_codepoint_decoder (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [u8cpd_pkg::REQ_DATA_W-1:0]     req_tdata,   // [7:0] in_byte
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [u8cpd_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // [20:0] code_point, rest zero
   output logic                                 rsp_tlast,   // end_of_text
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [u8cpd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [u8cpd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [u8cpd_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                 csr_pready
);
   import u8cpd_pkg::*;

   logic            mode;
   logic            beat_en;
   result_beat_type dec_result;
   result_type      out_data;

   assign beat_en = req_tvalid && req_tready;

   u8cpd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .mode        (mode)
   );

   u8cpd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .beat_en (beat_en),
      .in_byte (req_tdata[BYTE_W-1:0]),
      .mode    (mode),
      .result  (dec_result)
   );

   u8cpd_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (dec_result),
      .push_ready (req_tready),
      .out_valid  (rsp_tvalid),
      .out_data   (out_data),
      .out_ready  (rsp_tready)
   );

   assign rsp_tdata = {{(RSP_DATA_W-CP_W){1'b0}}, out_data.code_point};
   assign rsp_tlast = out_data.end_of_text;

endmodule

FILE: verif/utf8_codepoint_decoder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for utf8_codepoint_decoder: directed and random byte streams in
// both encoding modes, with random stalls on both streams and results checked beat by beat.
// Depends on u8cpd_pkg and the utf8_codepoint_decoder RTL.
module utf8_codepoint_decoder_tb;
   import u8cpd_pkg::*;

   localparam int unsigned LIMIT_CYCLES = 400000;
   localparam int unsigned DRAIN_SLACK  = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;   // [7:0] in_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // [20:0] code_point, rest zero
   logic                  rsp_tlast;          // end_of_text
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   utf8_codepoint_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Text bytes waiting to be sent, and code points the decoder still owes us.
   logic [BYTE_W-1:0] text_bytes[$];
   result_type        expected_points[$];

   // Shadow of the decoder's sequence state and mode register.
   logic [PARTIAL_W-1:0] seq_partial = '0;
   logic [REMAIN_W-1:0]  seq_left    = '0;
   logic                 mode_shadow = MODE_UTF8;

   int unsigned error_count  = 0;
   int unsigned cycle_count  = 0;
   int unsigned send_gap     = 0;
   int unsigned recv_gap     = 0;
   logic        send_idle_on = 1'b1;
   logic        recv_idle_on = 1'b1;
   logic        next_valid;
   result_type  want;

   task automatic decode_byte(input logic [BYTE_W-1:0] b);
      logic [CP_W-1:0] merged;
      result_type      r;
      r.end_of_text = 1'b0;
      if (seq_left != 0) begin
         merged = {seq_partial, 6'b000000} | CP_W'(b & MASK_CONT);
         if (seq_left == 1) begin
            r.code_point = merged;
            expected_points.push_back(r);
            seq_partial = '0;
            seq_left    = '0;
         end else begin
            seq_partial = merged[PARTIAL_W-1:0];
            seq_left    = seq_left - 1'b1;
         end
      end else if (b == 0) begin
         r.code_point  = '0;
         r.end_of_text = 1'b1;
         expected_points.push_back(r);
      end else if (mode_shadow == MODE_RAW || b <= LEAD_ASCII_MAX || b > LEAD_FOUR_MAX) begin
         r.code_point = CP_W'(b);
         expected_points.push_back(r);
      end else if (b <= LEAD_TWO_MAX) begin
         seq_partial = PARTIAL_W'(b & MASK_TWO);
         seq_left    = 2'd1;
      end else if (b <= LEAD_THREE_MAX) begin
         seq_partial = PARTIAL_W'(b & MASK_THREE);
         seq_left    = 2'd2;
      end else begin
         seq_partial = PARTIAL_W'(b & MASK_FOUR);
         seq_left    = 2'd3;
      end
   endtask

   // Byte driver: holds each beat until it is taken, with random gaps between beats.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata);
         end
         if (!req_tvalid || req_tready) begin
            next_valid = 1'b0;
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
            end else if (text_bytes.size() > 0) begin
               next_valid = 1'b1;
               req_tdata <= text_bytes.pop_front();
               if (send_idle_on && $urandom_range(0, 7) == 0) begin
                  send_gap = $urandom_range(1, 19);
               end
            end
            req_tvalid <= next_valid;
         end
      end
   end

   // Result monitor with random back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_points.size() == 0) begin
               $error("unexpected result beat: code_point %0h, end_of_text %0b",
                      rsp_tdata[CP_W-1:0], rsp_tlast);
               error_count++;
            end else begin
               want = expected_points.pop_front();
               if (rsp_tdata[CP_W-1:0] !== want.code_point) begin
                  $error("code_point mismatch: expected %0h, actual %0h",
                         want.code_point, rsp_tdata[CP_W-1:0]);
                  error_count++;
               end
               if (rsp_tlast !== want.end_of_text) begin
                  $error("end_of_text mismatch: expected %0b, actual %0b",
                         want.end_of_text, rsp_tlast);
                  error_count++;
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap = recv_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (recv_idle_on && $urandom_range(0, 9) == 0) begin
               recv_gap = $urandom_range(1, 19);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Writes the mode register, then reads it back.
   task automatic set_mode(input logic value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_MODE;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      mode_shadow = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== CSR_DATA_W'(value)) begin
         $error("encoding_mode readback mismatch: expected %0h, actual %0h",
                CSR_DATA_W'(value), csr_prdata);
         error_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Waits until every byte is taken and every owed code point has come back.
   // The check runs on the falling edge so the driver and monitor updates have settled.
   task automatic wait_idle();
      while (text_bytes.size() != 0 || req_tvalid || expected_points.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   // Mostly well-formed sequences with random payload; some stray bytes, truncated
   // sequences and corrupted continuations mixed in.
   task automatic queue_random_text(input int unsigned n_bytes);
      int unsigned       added;
      int unsigned       pick;
      int unsigned       conts;
      int unsigned       k;
      logic [BYTE_W-1:0] lead;
      logic [BYTE_W-1:0] cont;
      added = 0;
      while (added < n_bytes) begin
         pick  = $urandom_range(0, 99);
         conts = 0;
         if (pick < 20) begin
            lead = BYTE_W'($urandom_range(1, 127));
         end else if (pick < 24) begin
            lead = 8'h00;
         end else if (pick < 42) begin
            lead  = BYTE_W'($urandom_range(8'h80, 8'hDF));
            conts = 1;
         end else if (pick < 62) begin
            lead  = BYTE_W'($urandom_range(8'hE0, 8'hEF));
            conts = 2;
         end else if (pick < 82) begin
            lead  = BYTE_W'($urandom_range(8'hF0, 8'hF4));
            conts = 3;
         end else if (pick < 90) begin
            lead = BYTE_W'($urandom_range(8'hF5, 8'hFF));
         end else begin
            lead = BYTE_W'($urandom_range(0, 255));
         end
         if (conts > 0 && $urandom_range(0, 15) == 0) begin
            conts = $urandom_range(0, conts - 1);
         end
         text_bytes.push_back(lead);
         added++;
         for (k = 0; k < conts; k++) begin
            if ($urandom_range(0, 15) == 0) begin
               cont = BYTE_W'($urandom_range(0, 255));
            end else begin
               cont = 8'h80 | BYTE_W'($urandom_range(0, 63));
            end
            text_bytes.push_back(cont);
            added++;
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      set_mode(MODE_UTF8);

      // ASCII limits and end of text, two-byte leads including the low 0x80 lead,
      // three- and four-byte sequences, raw leads above 0xF4, a zero continuation,
      // and finally a sequence left open across the switch to raw mode.
      text_bytes = '{8'h01, 8'h7F, 8'h00, 8'hC2, 8'hA9, 8'h80, 8'hBF, 8'hDF, 8'hFF,
                     8'hE2, 8'h82, 8'hAC, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hF5, 8'hFF,
                     8'hC3, 8'h00, 8'hE2, 8'h82};
      wait_idle();
      set_mode(MODE_RAW);
      // The first byte still finishes the open sequence as UTF-8.
      text_bytes = '{8'hAC, 8'h00, 8'h80, 8'hC3, 8'hFF};
      wait_idle();

      set_mode(MODE_UTF8);
      queue_random_text(600);
      wait_idle();
      set_mode(MODE_RAW);
      queue_random_text(300);
      wait_idle();
      set_mode(MODE_UTF8);
      queue_random_text(400);
      wait_idle();

      // Closing stretch at full rate on both sides.
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      set_mode(MODE_RAW);
      queue_random_text(100);
      wait_idle();
      set_mode(MODE_UTF8);
      queue_random_text(300);
      wait_idle();

      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: utf8_codepoint_decoder.f
sv/u8cpd_pkg.sv
sv/u8cpd_csr.sv
sv/u8cpd_decode.sv
sv/u8cpd_out_buf.sv
sv/utf8_codepoint_decoder.sv
verif/utf8_codepoint_decoder_tb.sv
